/* rtl/dtq_pkg.sv */
// Shared types and constants for the deadline timeout queue.
`default_nettype none
package dtq_pkg;
    localparam int ENTRIES = 64;
    localparam int ID_W = 6;
    localparam int LINK_W = 7;
    localparam logic [LINK_W-1:0] NO_ENTRY = 7'd64;
    localparam logic [63:0] NEVER_TICKS = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_REMOVE  = 3'd1;
    localparam logic [2:0] MODE_CHECK   = 3'd2;
    localparam logic [2:0] MODE_INSTALL = 3'd3;
    localparam logic [2:0] MODE_CANCEL  = 3'd4;
    localparam logic [2:0] MODE_CLEAR   = 3'd5;

    localparam logic [2:0] KIND_DONE        = 3'd0;
    localparam logic [2:0] KIND_EXP_FIRED   = 3'd1;
    localparam logic [2:0] KIND_EXP_CANCEL  = 3'd2;
    localparam logic [2:0] KIND_EXP_NONE    = 3'd3;
    localparam logic [2:0] KIND_CAN_FIRED   = 3'd4;
    localparam logic [2:0] KIND_CAN_BUSY    = 3'd5;

    localparam logic [1:0] CS_NONE      = 2'd0;
    localparam logic [1:0] CS_HANDLER   = 2'd1;
    localparam logic [1:0] CS_CANCELLED = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  request_id;
        logic [63:0] timeout;
        logic [63:0] now;
    } dtq_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  entry_id;
        logic        timer_program;
        logic [63:0] timer_deadline;
        logic        last;
    } dtq_out_t;
endpackage
`default_nettype wire

/* rtl/deadline_timeout_queue_core.sv */
// Top level of the deadline timeout queue: linked-list sequencer over entry memories.
// Add walks the list with one memory read per visited entry (states WALK and WCMP);
// check pops expired entries from the head through states CHK, CCMP and CPOP.
// Remove unlinks in UNL. One item at a time; the next is taken once the
// result register is free. Reset (aresetn low, synchronous) clears the armed flags,
// cancel states, head and tail at once; the link and deadline memories stay unset.
`default_nettype none
module deadline_timeout_queue_core
    import dtq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dtq_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dtq_out_t      m_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_UNL   = 4'd2;
    localparam logic [3:0] ST_UNL2  = 4'd3;
    localparam logic [3:0] ST_WALK  = 4'd4;
    localparam logic [3:0] ST_WCMP  = 4'd5;
    localparam logic [3:0] ST_INS   = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_CCMP  = 4'd8;
    localparam logic [3:0] ST_CPOP  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // entry memories: deadline, next, prev
    logic [63:0]       dl_mem [ENTRIES];
    logic [LINK_W-1:0] nx_mem [ENTRIES];
    logic [LINK_W-1:0] pv_mem [ENTRIES];

    logic [ENTRIES-1:0] armed_reg;
    logic [1:0]         cs_reg [ENTRIES];
    logic [LINK_W-1:0]  head_reg, tail_reg;
    logic [3:0]         st_reg;
    dtq_in_t            in_reg;
    logic [63:0]        dl_reg;     // new deadline for add
    logic [LINK_W-1:0]  e_reg;      // walk cursor
    logic [LINK_W-1:0]  p_reg;
    logic [6:0]         cnt_reg;
    logic               popped_reg;
    logic [5:0]         lastid_reg;
    logic [2:0]         lastkind_reg;

    // registered memory reads
    logic [5:0]        ra;
    logic [63:0]       rd_dl;
    logic [LINK_W-1:0] rd_nx, rd_pv;
    // one write per memory per cycle
    logic              we_dl, we_nx, we_pv;
    logic [5:0]        wa_dl, wa_nx, wa_pv;
    logic [63:0]       wd_dl;
    logic [LINK_W-1:0] wd_nx, wd_pv;
    // insert writes the neighbour links in ST_UNL2, the state after ST_INS
    logic [64:0]       sum;
    logic              out_free;
    logic              load_out;

    assign sum = {1'b0, in_reg.now} + {1'b0, in_reg.timeout};
    assign s_ready = (st_reg == ST_IDLE) && !m_valid;
    assign out_free = !m_valid || m_ready;
    // load the result register at the end of an item or for an intermediate check word
    assign load_out = out_free &&
                      ((st_reg == ST_OUT) ||
                       (st_reg == ST_CCMP && popped_reg && !(rd_dl > in_reg.now)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (load_out) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_dl <= dl_mem[ra];
        rd_nx <= nx_mem[ra];
        rd_pv <= pv_mem[ra];
        if (we_dl) dl_mem[wa_dl] <= wd_dl;
        if (we_nx) nx_mem[wa_nx] <= wd_nx;
        if (we_pv) pv_mem[wa_pv] <= wd_pv;
    end

    logic [5:0] id6;
    logic [5:0] e6;
    assign id6 = in_reg.request_id;
    assign e6  = e_reg[5:0];

    always_comb begin
        ra = id6;
        we_dl = 1'b0; we_nx = 1'b0; we_pv = 1'b0;
        wa_dl = id6;  wa_nx = id6;  wa_pv = id6;
        wd_dl = dl_reg; wd_nx = NO_ENTRY; wd_pv = NO_ENTRY;
        case (st_reg)
            ST_WALK: ra = e6;
            ST_CHK, ST_CCMP: ra = head_reg[5:0];
            ST_UNL: begin
                // rd has prev/next of id; fix neighbor next and prev pointers
                if (rd_pv != NO_ENTRY) begin
                    we_nx = 1'b1; wa_nx = rd_pv[5:0]; wd_nx = rd_nx;
                end
                if (rd_nx != NO_ENTRY) begin
                    we_pv = 1'b1; wa_pv = rd_nx[5:0]; wd_pv = rd_pv;
                end
            end
            ST_INS: begin
                we_dl = 1'b1; wa_dl = id6; wd_dl = dl_reg;
                we_nx = 1'b1; wa_nx = id6; wd_nx = e_reg;
                we_pv = 1'b1; wa_pv = id6; wd_pv = p_reg;
            end
            ST_UNL2: begin
                // insert neighbor links: prev of e and next of p
                if (p_reg != NO_ENTRY) begin
                    we_nx = 1'b1; wa_nx = p_reg[5:0]; wd_nx = {1'b0, id6};
                end
                if (e_reg != NO_ENTRY) begin
                    we_pv = 1'b1; wa_pv = e6; wd_pv = {1'b0, id6};
                end
            end
            ST_CPOP: begin
                if (rd_nx != NO_ENTRY) begin
                    we_pv = 1'b1; wa_pv = rd_nx[5:0]; wd_pv = NO_ENTRY;
                end
                we_dl = 1'b1; wa_dl = head_reg[5:0]; wd_dl = NEVER_TICKS;
            end
            default: ;
        endcase
    end

    // ST_UNL2 writes the neighbour links after insert; ins_phase set marks a remove, which ends after ST_UNL
    logic ins_phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            armed_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) cs_reg[i] <= CS_NONE;
            head_reg <= NO_ENTRY;
            tail_reg <= NO_ENTRY;
            ins_phase_reg <= 1'b0;
            popped_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg <= s_data;
                        st_reg <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    m_data.entry_id <= id6;
                    m_data.kind <= KIND_DONE;
                    m_data.timer_program <= 1'b0;
                    m_data.timer_deadline <= '0;
                    m_data.last <= 1'b1;
                    st_reg <= ST_OUT;
                    case (in_reg.mode)
                        MODE_ADD: begin
                            if (in_reg.timeout != NEVER_TICKS) begin
                                dl_reg <= sum[64] ? NEVER_TICKS : sum[63:0];
                                ins_phase_reg <= 1'b0;
                                st_reg <= armed_reg[id6] ? ST_UNL : ST_WALK;
                                e_reg <= head_reg;
                                p_reg <= NO_ENTRY;
                            end
                        end
                        MODE_REMOVE: begin
                            if (armed_reg[id6]) begin
                                ins_phase_reg <= 1'b1;
                                st_reg <= ST_UNL;
                            end
                        end
                        MODE_CHECK: begin
                            m_data.entry_id <= '0;
                            cnt_reg <= '0;
                            popped_reg <= 1'b0;
                            st_reg <= ST_CHK;
                        end
                        MODE_INSTALL: cs_reg[id6] <= CS_HANDLER;
                        MODE_CANCEL: begin
                            cs_reg[id6] <= CS_CANCELLED;
                            m_data.kind <= (cs_reg[id6] == CS_HANDLER) ?
                                           KIND_CAN_FIRED : KIND_CAN_BUSY;
                        end
                        MODE_CLEAR: cs_reg[id6] <= CS_NONE;
                        default: ;
                    endcase
                end
                ST_UNL: begin
                    // read issued in ST_DEC at id; data valid now
                    if (rd_pv == NO_ENTRY) head_reg <= rd_nx;
                    if (rd_nx == NO_ENTRY) tail_reg <= rd_pv;
                    armed_reg[id6] <= 1'b0;
                    if (ins_phase_reg) begin
                        st_reg <= ST_OUT;
                    end else begin
                        e_reg <= (rd_pv == NO_ENTRY) ? rd_nx : head_reg;
                        p_reg <= NO_ENTRY;
                        st_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (e_reg == NO_ENTRY) st_reg <= ST_INS;
                    else st_reg <= ST_WCMP;
                end
                ST_WCMP: begin
                    if (dl_reg < rd_dl) begin
                        st_reg <= ST_INS;
                    end else begin
                        p_reg <= e_reg;
                        e_reg <= rd_nx;
                        st_reg <= ST_WALK;
                    end
                end
                ST_INS: begin
                    // e at end: p is tail
                    if (p_reg == NO_ENTRY) head_reg <= {1'b0, id6};
                    if (e_reg == NO_ENTRY) tail_reg <= {1'b0, id6};
                    armed_reg[id6] <= 1'b1;
                    st_reg <= ST_UNL2;
                end
                ST_UNL2: begin
                    m_data.timer_program <= 1'b1;
                    m_data.timer_deadline <= dl_reg;
                    st_reg <= ST_OUT;
                end
                ST_CHK: begin
                    if (head_reg == NO_ENTRY || cnt_reg == 7'(ENTRIES)) begin
                        // hold the final word until the previous one is taken
                        if (out_free) begin
                            m_data.kind <= popped_reg ? lastkind_reg : KIND_DONE;
                            m_data.entry_id <= popped_reg ? lastid_reg : 6'd0;
                            m_data.timer_program <= 1'b0;
                            m_data.timer_deadline <= '0;
                            m_data.last <= 1'b1;
                            st_reg <= ST_OUT;
                        end
                    end else begin
                        st_reg <= ST_CCMP;
                    end
                end
                ST_CCMP: begin
                    if (!out_free) begin
                        st_reg <= ST_CCMP;  // hold until previous word taken
                    end else if (rd_dl > in_reg.now) begin
                        m_data.kind <= popped_reg ? lastkind_reg : KIND_DONE;
                        m_data.entry_id <= popped_reg ? lastid_reg : 6'd0;
                        m_data.timer_program <= 1'b1;
                        m_data.timer_deadline <= rd_dl;
                        m_data.last <= 1'b1;
                        st_reg <= ST_OUT;
                    end else begin
                        if (popped_reg) begin
                            m_data.kind <= lastkind_reg;
                            m_data.entry_id <= lastid_reg;
                            m_data.timer_program <= 1'b0;
                            m_data.timer_deadline <= '0;
                            m_data.last <= 1'b0;
                        end
                        st_reg <= ST_CPOP;
                    end
                end
                ST_CPOP: begin
                    head_reg <= rd_nx;
                    if (rd_nx == NO_ENTRY) tail_reg <= NO_ENTRY;
                    armed_reg[head_reg[5:0]] <= 1'b0;
                    cs_reg[head_reg[5:0]] <= CS_CANCELLED;
                    lastid_reg <= head_reg[5:0];
                    lastkind_reg <= (cs_reg[head_reg[5:0]] == CS_HANDLER) ? KIND_EXP_FIRED :
                                    (cs_reg[head_reg[5:0]] == CS_NONE) ? KIND_EXP_NONE :
                                    KIND_EXP_CANCEL;
                    popped_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 7'd1;
                    st_reg <= ST_CHK;
                end
                ST_OUT: begin
                    if (out_free) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // intermediate check word only issued when output free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE && s_valid && s_ready) |=> st_reg == ST_DEC)
        else $error("accepted word did not start decode");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == NO_ENTRY) |-> (tail_reg == NO_ENTRY || st_reg != ST_IDLE))
        else $error("head empty but tail set");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("ready while result pending");
endmodule
`default_nettype wire

/* sim/dtq_checker.sv */
// Checker for the deadline timeout queue: predicts each result word and compares it.
module dtq_checker
    import dtq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  dtq_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  dtq_out_t m_data,
    output int       fail_count,
    output int       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] q_deadline [ENTRIES];
    logic [6:0]  q_next [ENTRIES];
    logic [6:0]  q_prev [ENTRIES];
    logic        q_armed [ENTRIES];
    logic [1:0]  q_cstate [ENTRIES];
    logic [6:0]  q_head, q_tail;
    dtq_out_t    expected_words[$];

    initial begin
        fail_count = 0;
        pending_count = 0;
        q_head = NO_ENTRY;
        q_tail = NO_ENTRY;
        for (int i = 0; i < ENTRIES; i++) begin
            q_armed[i] = 1'b0;
            q_cstate[i] = CS_NONE;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic dtq_out_t make_word(logic [2:0] k, logic [5:0] id, logic p,
                                           logic [63:0] dl, logic l);
        dtq_out_t w;
        w.kind = k;
        w.entry_id = id;
        w.timer_program = p;
        w.timer_deadline = dl;
        w.last = l;
        return w;
    endfunction

    task automatic unlink(input logic [5:0] id);
        logic [6:0] p, n;
        p = q_prev[id];
        n = q_next[id];
        if (p < NO_ENTRY) q_next[p[5:0]] = n; else q_head = n;
        if (n < NO_ENTRY) q_prev[n[5:0]] = p; else q_tail = p;
        q_armed[id] = 1'b0;
    endtask

    task automatic insert_by_deadline(input logic [5:0] id);
        logic [6:0] e, p;
        int steps;
        e = q_head;
        steps = 0;
        while (e < NO_ENTRY && steps < ENTRIES) begin
            if (q_deadline[id] < q_deadline[e[5:0]]) break;
            e = q_next[e[5:0]];
            steps++;
        end
        if (e >= NO_ENTRY) begin
            q_prev[id] = q_tail;
            q_next[id] = NO_ENTRY;
            if (q_tail < NO_ENTRY) q_next[q_tail[5:0]] = {1'b0, id};
            else q_head = {1'b0, id};
            q_tail = {1'b0, id};
        end else begin
            p = q_prev[e[5:0]];
            q_prev[id] = p;
            q_next[id] = e;
            q_prev[e[5:0]] = {1'b0, id};
            if (p < NO_ENTRY) q_next[p[5:0]] = {1'b0, id}; else q_head = {1'b0, id};
        end
        q_armed[id] = 1'b1;
    endtask

    task automatic predict_words(input dtq_in_t item);
        logic [5:0] id;
        int cnt;
        logic [63:0] dl;
        logic prog;
        logic [6:0] h;
        logic [1:0] old;
        logic [2:0] k;
        dtq_out_t w;
        id = item.request_id;
        if (item.mode == MODE_CHECK) begin
            cnt = 0;
            prog = 1'b0;
            dl = '0;
            while (cnt < ENTRIES) begin
                h = q_head;
                if (h >= NO_ENTRY) break;
                if (q_deadline[h[5:0]] > item.now) begin
                    prog = 1'b1;
                    dl = q_deadline[h[5:0]];
                    break;
                end
                unlink(h[5:0]);
                q_deadline[h[5:0]] = NEVER_TICKS;
                old = q_cstate[h[5:0]];
                q_cstate[h[5:0]] = CS_CANCELLED;
                k = (old == CS_HANDLER) ? KIND_EXP_FIRED :
                    (old == CS_NONE) ? KIND_EXP_NONE : KIND_EXP_CANCEL;
                expected_words.push_back(make_word(k, h[5:0], 1'b0, '0, 1'b0));
                cnt++;
            end
            if (cnt == 0) begin
                expected_words.push_back(make_word(KIND_DONE, '0, prog, dl, 1'b1));
            end else begin
                w = expected_words.pop_back();
                w.timer_program = prog;
                w.timer_deadline = dl;
                w.last = 1'b1;
                expected_words.push_back(w);
            end
            return;
        end
        case (item.mode)
            MODE_ADD: begin
                if (item.timeout != NEVER_TICKS) begin
                    dl = item.now + item.timeout;
                    if (dl < item.now) dl = NEVER_TICKS;
                    if (q_armed[id]) unlink(id);
                    q_deadline[id] = dl;
                    insert_by_deadline(id);
                    expected_words.push_back(make_word(KIND_DONE, id, 1'b1, dl, 1'b1));
                    return;
                end
            end
            MODE_REMOVE: if (q_armed[id]) unlink(id);
            MODE_INSTALL: q_cstate[id] = CS_HANDLER;
            MODE_CANCEL: begin
                old = q_cstate[id];
                q_cstate[id] = CS_CANCELLED;
                expected_words.push_back(make_word(
                    (old == CS_HANDLER) ? KIND_CAN_FIRED : KIND_CAN_BUSY, id, 1'b0, '0, 1'b1));
                return;
            end
            MODE_CLEAR: q_cstate[id] = CS_NONE;
            default: ;
        endcase
        expected_words.push_back(make_word(KIND_DONE, id, 1'b0, '0, 1'b1));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_words(s_data);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_data));
                end else begin
                    dtq_out_t e;
                    e = expected_words.pop_front();
                    if (m_data.kind !== e.kind)
                        report_mismatch($sformatf("kind %0d want %0d", m_data.kind, e.kind));
                    if (m_data.entry_id !== e.entry_id)
                        report_mismatch($sformatf("entry_id %0d want %0d",
                                                  m_data.entry_id, e.entry_id));
                    if (m_data.timer_program !== e.timer_program)
                        report_mismatch($sformatf("timer_program %0b want %0b",
                                                  m_data.timer_program, e.timer_program));
                    if (m_data.timer_deadline !== e.timer_deadline)
                        report_mismatch($sformatf("timer_deadline %h want %h",
                                                  m_data.timer_deadline, e.timer_deadline));
                    if (m_data.last !== e.last)
                        report_mismatch($sformatf("last %0b want %0b", m_data.last, e.last));
                end
            end
        end
        pending_count = expected_words.size();
    end
endmodule

/* sim/tb.sv */
// Testbench top for the deadline timeout queue: stimulus, idling and verdict.
module tb;
    import dtq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    dtq_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    dtq_out_t m_data;
    int       fail_count;
    int       pending_count;
    logic [63:0] uptime;
    int       checks_sent;
    bit       stall_on;

    deadline_timeout_queue_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    dtq_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Result side: random backpressure, switched off for some stretches.
    initial begin
        m_ready = 1'b0;
        stall_on = 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
            m_ready <= stall_on ? (gap_len() == 0) : 1'b1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_word(input logic [2:0] md, input logic [5:0] id,
                             input logic [63:0] tmo, input logic [63:0] nw);
        int g;
        g = stall_on ? gap_len() : 0;
        // advance to a later edge so valid is dropped before the next word
        repeat (g + 1) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= '{mode: md, request_id: id, timeout: tmo, now: nw};
        if (md == MODE_CHECK) checks_sent++;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic random_word();
        int r;
        logic [63:0] tmo;
        logic [5:0] id;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
        case ($urandom_range(0, 9))
            0: tmo = NEVER_TICKS;
            1: tmo = rand64();
            2: tmo = NEVER_TICKS - 64'($urandom_range(0, 3));
            default: tmo = 64'($urandom_range(0, 400));
        endcase
        uptime += 64'($urandom_range(0, 60));
        if (r < 40) send_word(MODE_ADD, id, tmo, uptime);
        else if (r < 55) send_word(MODE_CHECK, id, tmo, uptime);
        else if (r < 63) send_word(MODE_REMOVE, id, tmo, uptime);
        else if (r < 75) send_word(MODE_INSTALL, id, tmo, uptime);
        else if (r < 85) send_word(MODE_CANCEL, id, tmo, uptime);
        else if (r < 93) send_word(MODE_CLEAR, id, tmo, uptime);
        else send_word(3'($urandom_range(6, 7)), id, rand64(), rand64());
    endtask

    initial begin
        int wait_cycles;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        uptime = 64'd1000;
        checks_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every mode, ties, saturation, re-add, unused modes.
        send_word(MODE_CHECK, 6'd0, '0, '0);
        send_word(MODE_ADD, 6'd63, NEVER_TICKS, 64'd5);
        send_word(MODE_ADD, 6'd0, 64'd0, 64'd0);
        send_word(MODE_ADD, 6'd1, 64'd10, 64'd100);
        send_word(MODE_ADD, 6'd2, 64'd10, 64'd100);
        send_word(MODE_ADD, 6'd63, 64'd5, NEVER_TICKS);
        send_word(MODE_ADD, 6'd3, NEVER_TICKS - 1, 64'd2);
        send_word(MODE_ADD, 6'd1, 64'd200, 64'd100);
        send_word(MODE_INSTALL, 6'd2, '0, '0);
        send_word(MODE_CANCEL, 6'd2, '0, '0);
        send_word(MODE_CANCEL, 6'd2, '0, '0);
        send_word(MODE_INSTALL, 6'd63, '0, '0);
        send_word(MODE_REMOVE, 6'd40, '0, '0);
        send_word(MODE_REMOVE, 6'd0, '0, '0);
        send_word(MODE_CLEAR, 6'd2, NEVER_TICKS, NEVER_TICKS);
        send_word(3'd6, 6'd5, NEVER_TICKS, NEVER_TICKS);
        send_word(3'd7, 6'd63, '0, '0);
        send_word(MODE_CHECK, 6'd63, NEVER_TICKS, 64'd150);
        send_word(MODE_CHECK, 6'd0, '0, NEVER_TICKS);
        send_word(MODE_CHECK, 6'd0, '0, NEVER_TICKS);

        // Hold off until the queue of expected words drains.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);

        // Fill every entry, then pop them all in one check.
        for (int i = 0; i < ENTRIES; i++) begin
            if (i % 3 == 0) send_word(MODE_INSTALL, 6'(i), '0, '0);
            send_word(MODE_ADD, 6'(i), 64'($urandom_range(0, 30)), uptime);
        end
        send_word(MODE_CHECK, 6'd0, '0, uptime + 64'd31);

        for (int n = 0; n < 160; n++) random_word();
        send_word(MODE_CHECK, 6'd0, '0, NEVER_TICKS);

        @(posedge aclk);
        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (200) @(posedge aclk);
        $display("Covered all modes, full-list insert and pop, %0d checks, ties and saturation.",
                 checks_sent);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/dtq_pkg.sv
rtl/deadline_timeout_queue_core.sv
sim/dtq_checker.sv
sim/tb.sv
